>>> rtl/hrd_pkg.sv
// Shared types and constants for the H.264 RTP depacketizer.
// No dependencies; the parser, emitter, top level and testbench import this package.
`default_nettype none
package hrd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COPY     = 3'd1,
    PH_STAP_HI  = 3'd2,
    PH_STAP_LO  = 3'd3,
    PH_STAP_DAT = 3'd4,
    PH_FU_HDR   = 3'd5
  } phase_t;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_SINGLE_LO = 5'd1;
  localparam logic [4:0] NAL_SINGLE_HI = 5'd23;
  localparam logic [4:0] NAL_STAP_A    = 5'd24;
  localparam logic [4:0] NAL_FU_A      = 5'd28;

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_ONE  = 8'h01;

  // Result burst caused by one input byte: optional start code, optional
  // data byte, or a bare end marker.
  typedef struct packed {
    logic [2:0] cnt;
    logic       start;
    logic       has_data;
    logic       bare;
    logic       pkt_end;
    logic [7:0] data;
  } desc_t;

endpackage
`default_nettype wire

>>> rtl/hrd_if.sv
// Valid/ready channel interfaces for the depacketizer.
// Depends on nothing; payload fields match the stream formats.
`default_nettype none
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, payload_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, payload_byte, first_byte, last_byte, output ready);
endinterface

interface hrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       packet_end;
  modport source (output valid, out_byte, byte_valid, run_last, packet_end, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, packet_end, output ready);
endinterface
`default_nettype wire

>>> rtl/hrd_parser.sv
// Payload parser: phase register plus STAP-A / FU-A context, and the
// per-byte result descriptor. Depends on hrd_pkg.
`default_nettype none
module hrd_parser
  import hrd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] payload_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output desc_t           desc
);

  phase_t      phase, phase_next;
  logic [15:0] unit_rem, unit_rem_next;
  logic [7:0]  size_hi, size_hi_next;
  logic [2:0]  ind, ind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      unit_rem <= '0;
      size_hi  <= '0;
      ind      <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      unit_rem <= unit_rem_next;
      size_hi  <= size_hi_next;
      ind      <= ind_next;
    end
  end

  always_comb begin
    logic [4:0]  hdr_type;
    logic        forbidden;
    logic        ignore;
    logic [15:0] size;
    logic [15:0] rem_dec;
    hdr_type      = payload_byte[4:0] & NAL_TYPE_MASK;
    forbidden     = payload_byte[7];
    ignore        = 1'b0;
    size          = {size_hi, payload_byte};
    rem_dec       = unit_rem - 16'd1;
    phase_next    = phase;
    unit_rem_next = unit_rem;
    size_hi_next  = size_hi;
    ind_next      = ind;
    desc          = '0;
    desc.data     = payload_byte;

    if (first_byte) begin
      unit_rem_next = '0;
      size_hi_next  = '0;
      if (!forbidden && hdr_type inside {[NAL_SINGLE_LO:NAL_SINGLE_HI]}) begin
        desc.start    = 1'b1;
        desc.has_data = 1'b1;
        phase_next    = PH_COPY;
      end else if (!forbidden && hdr_type == NAL_STAP_A) begin
        phase_next = PH_STAP_HI;
      end else if (!forbidden && hdr_type == NAL_FU_A) begin
        ind_next   = payload_byte[7:5];
        phase_next = PH_FU_HDR;
      end else begin
        desc.has_data = 1'b1;
        phase_next    = PH_COPY;
      end
    end else begin
      case (phase)
        PH_COPY: begin
          desc.has_data = 1'b1;
        end
        PH_STAP_HI: begin
          size_hi_next = payload_byte;
          phase_next   = PH_STAP_LO;
        end
        PH_STAP_LO: begin
          unit_rem_next = size;
          if (size == 16'd0) begin
            phase_next = PH_STAP_HI;
          end else begin
            desc.start = 1'b1;
            phase_next = PH_STAP_DAT;
          end
        end
        PH_STAP_DAT: begin
          desc.has_data = 1'b1;
          unit_rem_next = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_next = PH_STAP_HI;
          end
        end
        PH_FU_HDR: begin
          if (payload_byte[7]) begin
            desc.start    = 1'b1;
            desc.has_data = 1'b1;
            desc.data     = {ind, payload_byte[4:0] & NAL_TYPE_MASK};
          end
          phase_next = PH_COPY;
        end
        default: begin
          // stray byte outside a packet: dropped, even with last set
          ignore     = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (last_byte && !ignore) begin
      desc.pkt_end  = 1'b1;
      desc.bare     = !desc.start && !desc.has_data;
      phase_next    = PH_IDLE;
      unit_rem_next = '0;
      size_hi_next  = '0;
      ind_next      = '0;
    end

    desc.cnt = {desc.start, 2'b00} + {2'b00, desc.has_data} + {2'b00, desc.bare};
  end

endmodule
`default_nettype wire

>>> rtl/hrd_emitter.sv
// Result sequencer: holds one descriptor and plays its bytes out through
// the output register. Depends on hrd_pkg and hrd_out_if.
`default_nettype none
module hrd_emitter
  import hrd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire desc_t desc,
  output logic       ready,
  hrd_out_if.source  stream
);

  desc_t      pend;
  logic [2:0] rem;
  logic       adv;
  logic [7:0] cur_byte;

  // move one result into the output register
  assign adv   = (rem != 3'd0) && (!stream.valid || stream.ready);
  assign ready = (rem == 3'd0) || ((rem == 3'd1) && adv);

  always_comb begin
    if (pend.has_data && rem == 3'd1) begin
      cur_byte = pend.data;
    end else if (pend.bare) begin
      cur_byte = START_ZERO;
    end else if (rem == (pend.has_data ? 3'd2 : 3'd1)) begin
      cur_byte = START_ONE;
    end else begin
      cur_byte = START_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (accept) begin
      rem <= desc.cnt;
    end else if (adv) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
    end else if (adv) begin
      stream.valid <= 1'b1;
    end else if (stream.ready) begin
      stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stream.out_byte   <= cur_byte;
      stream.byte_valid <= !pend.bare;
      stream.run_last   <= (rem == 3'd1);
      stream.packet_end <= (rem == 3'd1) && pend.pkt_end;
    end
  end

endmodule
`default_nettype wire

>>> rtl/h264_rtp_depacketizer.sv
// H.264 RTP payload to Annex B depacketizer, one payload byte per transfer.
// A byte's results pass from the pending descriptor into the output register.
// Throughput: one byte per cycle while the output is ready and bytes cause at most
// one result; a byte that causes n results (start code insertion gives four or five)
// holds the input until they leave the one-result-per-cycle output register.
// Reset (rst, synchronous): parser idle, context zero, no pending results.
`default_nettype none
module h264_rtp_depacketizer
  import hrd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  hrd_in_if.sink   payload,
  hrd_out_if.source stream
);

  desc_t desc;
  logic  accept;
  logic  rdy;

  assign payload.ready = rdy;
  assign accept        = payload.valid && rdy;

  hrd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload.payload_byte),
    .first_byte   (payload.first_byte),
    .last_byte    (payload.last_byte),
    .desc         (desc)
  );

  hrd_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .desc   (desc),
    .ready  (rdy),
    .stream (stream)
  );

endmodule
`default_nettype wire

>>> rtl/hrd_checker.sv
// Port-level checks for the depacketizer, bound to the top level.
// Depends only on the top level's port signals.
`default_nettype none
module hrd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       run_last,
  input wire logic       packet_end
);

  // a stalled transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(run_last) && $stable(packet_end))
    else $error("output changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> run_last)
    else $error("packet_end without run_last");

  a_bare: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> packet_end && run_last && out_byte == 8'h00)
    else $error("malformed bare end marker");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind h264_rtp_depacketizer hrd_checker u_hrd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (stream.valid),
  .out_ready  (stream.ready),
  .out_byte   (stream.out_byte),
  .byte_valid (stream.byte_valid),
  .run_last   (stream.run_last),
  .packet_end (stream.packet_end)
);
`default_nettype wire

>>> verif/h264_rtp_depacketizer_tb.sv
// Self-checking testbench for h264_rtp_depacketizer: RTP payload bytes in, Annex B bytes out.
// Needs hrd_pkg and the hrd_in_if / hrd_out_if interfaces from the rtl folder.
// A built-in Annex B predictor is compared against every output transfer.
module h264_rtp_depacketizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrd_pkg::*;

  localparam int         ITEM_TARGET  = 460;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         LONG_HOLD    = 250;
  localparam int         LONG_HOLD_AT = 150;
  localparam int         DRAIN_EVERY  = 170;
  localparam logic [7:0] FORBIDDEN    = 8'h80;
  localparam logic [7:0] FU_START     = 8'h80;
  localparam logic [7:0] FU_END       = 8'h40;
  localparam logic [4:0] NAL_UNSPEC   = 5'd0;

  typedef struct {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    bit         drain;     // hold this byte until the output side has caught up
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       pkt_end;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrd_in_if  in_ch();
  hrd_out_if out_ch();

  h264_rtp_depacketizer u_top (
    .clk     (clk),
    .rst     (rst),
    .payload (in_ch),
    .stream  (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stim_t   item_q[$];
  result_t annexb_expected[$];
  int      n_items = 0;
  bit      drain_next = 1'b0;
  int      exp_count = 0;
  int      got_count = 0;
  int      failures = 0;
  int      idle_cycles = 0;

  // predictor state
  phase_t      parse_st;
  logic [15:0] unit_left;
  logic [7:0]  size_hi;
  logic [2:0]  fu_nri;

  // Runs one payload byte through the parser, queues its Annex B bytes, returns their count.
  function automatic int depacketize_byte(input stim_t it);
    logic [7:0] emit[$];
    bit         lead;
    result_t    r;
    logic [4:0] hdr_type;
    logic       forbid;
    lead     = 1'b0;
    hdr_type = it.data[4:0];
    forbid   = it.data[7];
    if (it.is_first) begin
      unit_left = '0;
      size_hi   = '0;
      if (!forbid && hdr_type >= NAL_SINGLE_LO && hdr_type <= NAL_SINGLE_HI) begin
        lead = 1'b1;
        emit.push_back(it.data);
        parse_st = PH_COPY;
      end else if (!forbid && hdr_type == NAL_STAP_A) begin
        parse_st = PH_STAP_HI;
      end else if (!forbid && hdr_type == NAL_FU_A) begin
        fu_nri   = it.data[7:5];
        parse_st = PH_FU_HDR;
      end else begin
        emit.push_back(it.data);
        parse_st = PH_COPY;
      end
    end else begin
      case (parse_st)
        PH_COPY: emit.push_back(it.data);
        PH_STAP_HI: begin
          size_hi  = it.data;
          parse_st = PH_STAP_LO;
        end
        PH_STAP_LO: begin
          unit_left = {size_hi, it.data};
          if (unit_left == '0) begin
            parse_st = PH_STAP_HI;
          end else begin
            lead     = 1'b1;
            parse_st = PH_STAP_DAT;
          end
        end
        PH_STAP_DAT: begin
          emit.push_back(it.data);
          unit_left = unit_left - 16'd1;
          if (unit_left == '0) parse_st = PH_STAP_HI;
        end
        PH_FU_HDR: begin
          if (it.data[7]) begin
            lead = 1'b1;
            emit.push_back({fu_nri, it.data[4:0]});
          end
          parse_st = PH_COPY;
        end
        default: return 0;  // stray byte outside a packet
      endcase
    end
    if (lead) begin
      emit.push_front(START_ONE);
      emit.push_front(START_ZERO);
      emit.push_front(START_ZERO);
      emit.push_front(START_ZERO);
    end
    if (it.is_last && emit.size() == 0) begin
      r = '{data: 8'h00, byte_valid: 1'b0, run_last: 1'b1, pkt_end: 1'b1};
      annexb_expected.push_back(r);
    end
    foreach (emit[i]) begin
      r.data       = emit[i];
      r.byte_valid = 1'b1;
      r.run_last   = (i == emit.size() - 1);
      r.pkt_end    = it.is_last && r.run_last;
      annexb_expected.push_back(r);
    end
    if (it.is_last) begin
      parse_st  = PH_IDLE;
      unit_left = '0;
      size_hi   = '0;
      fu_nri    = '0;
      return (emit.size() == 0) ? 1 : emit.size();
    end
    return emit.size();
  endfunction

  // ---------------- driver ----------------
  int in_gap = 0;
  int n_accepted = 0;

  always @(posedge clk) begin
    int n_new;
    int exp_now;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap    = 0;
      parse_st  = PH_IDLE;
      unit_left = '0;
      size_hi   = '0;
      fu_nri    = '0;
    end else begin
      n_new = 0;
      if (in_ch.valid && in_ch.ready) begin
        n_new = depacketize_byte(item_q[0]);
        exp_count <= exp_count + n_new;
        item_q.pop_front();
        n_accepted++;
        // every fourth block of 64 bytes goes back to back
        in_gap = ((n_accepted / 64) % 4 == 3) ? 0 : $urandom_range(0, 7);
      end
      exp_now = exp_count + n_new;
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (item_q.size() != 0 && (!item_q[0].drain || exp_now == got_count)) begin
          in_ch.valid        <= 1'b1;
          in_ch.payload_byte <= item_q[0].data;
          in_ch.first_byte   <= item_q[0].is_first;
          in_ch.last_byte    <= item_q[0].is_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int out_gap = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap   = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_count <= got_count + 1;
        if (annexb_expected.size() == 0) begin
          $error("unexpected output transfer: out_byte %h byte_valid %b", out_ch.out_byte,
                 out_ch.byte_valid);
          failures++;
        end else begin
          want = annexb_expected.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
            failures++;
          end
          if (out_ch.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, out_ch.byte_valid);
            failures++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
            failures++;
          end
          if (out_ch.packet_end !== want.pkt_end) begin
            $error("packet_end: expected %b, got %b", want.pkt_end, out_ch.packet_end);
            failures++;
          end
        end
        out_gap = ((got_count / 128) % 4 == 1) ? 0 : $urandom_range(0, 7);
        // one long back-pressure stretch so the input side fills and stalls
        if (got_count == LONG_HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** h264_rtp_depacketizer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_item(input logic [7:0] d, input logic f, input logic l,
                           input bit counted);
    stim_t it;
    it = '{data: d, is_first: f, is_last: l, drain: drain_next};
    item_q.push_back(it);
    drain_next = 1'b0;
    if (counted) n_items++;
  endtask

  // ends = 0 leaves the packet open so the next start byte abandons it
  task automatic send_packet(input logic [7:0] bytes[$], input bit ends);
    foreach (bytes[i]) push_item(bytes[i], i == 0, ends && i == bytes.size() - 1, 1'b1);
  endtask

  initial begin
    logic [7:0]  pkt[$];
    logic [7:0]  hdr;
    logic [1:0]  nri;
    logic [4:0]  t;
    logic [15:0] size;
    int          kind;
    int          units;
    int          fate;
    int          cut;
    int          next_drain_at;
    bit          big;

    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.first_byte   = 1'b0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;

    // directed: single NAL, type extremes, forbidden bit, raw type 0
    pkt = {{1'b0, 2'b01, NAL_SINGLE_LO}, 8'hFF};
    send_packet(pkt, 1'b1);
    pkt = {{1'b0, 2'b11, NAL_SINGLE_HI}};
    send_packet(pkt, 1'b1);
    pkt = {8'hFF, 8'h12};
    send_packet(pkt, 1'b1);
    pkt = {{1'b0, 2'b00, NAL_UNSPEC}};
    send_packet(pkt, 1'b1);
    // STAP-A with a zero-length unit in the middle
    pkt = {{1'b0, 2'b11, NAL_STAP_A}, 8'h00, 8'h02, 8'hAA, 8'h55, 8'h00, 8'h00,
           8'h00, 8'h01, 8'hC3};
    send_packet(pkt, 1'b1);
    // FU-A with start and end both set, then a middle fragment (bare end)
    pkt = {{1'b0, 2'b10, NAL_FU_A}, FU_START | FU_END | 8'h05, 8'h77};
    send_packet(pkt, 1'b1);
    pkt = {{1'b0, 2'b10, NAL_FU_A}, 8'h05};
    send_packet(pkt, 1'b1);
    // stray bytes while idle are dropped
    push_item(8'h5A, 1'b0, 1'b1, 1'b0);
    push_item(8'h33, 1'b0, 1'b0, 1'b0);
    // packet abandoned by a new start, then an FU-A cut before its header
    pkt = {{1'b0, 2'b01, NAL_SINGLE_LO}, 8'h44};
    send_packet(pkt, 1'b0);
    pkt = {{1'b0, 2'b00, NAL_FU_A}};
    send_packet(pkt, 1'b1);

    next_drain_at = n_items + 1;
    while (n_items < ITEM_TARGET) begin
      if (n_items >= next_drain_at) begin
        drain_next    = 1'b1;
        next_drain_at = next_drain_at + DRAIN_EVERY;
      end
      kind = $urandom_range(0, 99);
      pkt.delete();
      nri = 2'($urandom);
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 1'($urandom), 1'b0);
        continue;
      end else if (kind < 33) begin
        pkt.push_back({1'b0, nri, 5'($urandom_range(1, 23))});
        repeat ($urandom_range(0, 10)) pkt.push_back(8'($urandom));
      end else if (kind < 60) begin
        pkt.push_back({1'b0, nri, NAL_STAP_A});
        units = $urandom_range(1, 3);
        for (int u = 0; u < units; u++) begin
          big  = ($urandom_range(0, 9) == 0);
          size = big ? 16'($urandom) : 16'($urandom_range(0, 6));
          pkt.push_back(size[15:8]);
          pkt.push_back(size[7:0]);
          if (size > 16'd8) begin
            // huge unit: send a few bytes and let the packet end inside it
            repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
            break;
          end
          repeat (size) pkt.push_back(8'($urandom));
        end
      end else if (kind < 84) begin
        pkt.push_back({1'b0, nri, NAL_FU_A});
        pkt.push_back(8'($urandom));
        repeat ($urandom_range(0, 10)) pkt.push_back(8'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          hdr = 8'($urandom) | FORBIDDEN;
        end else begin
          do t = 5'($urandom);
          while (t != NAL_UNSPEC &&
                 (t <= NAL_SINGLE_HI || t == NAL_STAP_A || t == NAL_FU_A));
          hdr = {1'b0, nri, t};
        end
        pkt.push_back(hdr);
        repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
      end
      fate = $urandom_range(0, 99);
      if (fate < 8) begin
        send_packet(pkt, 1'b0);
      end else if (fate < 16) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
        send_packet(pkt, 1'b1);
      end else begin
        send_packet(pkt, 1'b1);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || exp_count != got_count) @(posedge clk);
    repeat (10) @(posedge clk);

    if (annexb_expected.size() != 0) begin
      $error("%0d expected output bytes never arrived", annexb_expected.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** h264_rtp_depacketizer: PASSED **");
    end else begin
      $display("** h264_rtp_depacketizer: FAILED **");
    end
    $finish;
  end

endmodule

>>> h264_rtp_depacketizer.f
rtl/hrd_pkg.sv
rtl/hrd_if.sv
rtl/hrd_parser.sv
rtl/hrd_emitter.sv
rtl/h264_rtp_depacketizer.sv
rtl/hrd_checker.sv
verif/h264_rtp_depacketizer_tb.sv
